// ----- rtl/core/lev_pkg.sv -----
// ----------------------------------------------------------------------------
// lev_pkg
// Shared types and codes for the Levenshtein distance block: word modes,
// counter limits and the operand bundle of the cell update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lev_pkg;

    // Word modes carried on the slave tuser
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STREAM = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // Width of distances and of the streamed byte counter
    localparam int unsigned DIST_W = 16;

    // Streamed bytes beyond this count are dropped
    localparam logic [DIST_W-1:0] STREAM_LIMIT = 16'hFFFF;

    // Operands of one cell of the one-row recurrence
    typedef struct packed {
        logic              bytes_eq;   // compared byte matches reference byte
        logic [DIST_W-1:0] diag;       // old row value at j
        logic [DIST_W-1:0] left;       // new row value at j
        logic [DIST_W-1:0] up;         // old row value at j+1
    } t_cell_in;

endpackage

`default_nettype wire

// ----- rtl/core/lev_cell.sv -----
// ----------------------------------------------------------------------------
// lev_cell
// Shared cell update unit: new value of one row entry from its diagonal,
// left and upper neighbors and the byte match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lev_cell
    import lev_pkg::*;
(
    input  var t_cell_in          i_cell,
    output logic [DIST_W-1:0]     o_value
);

    logic [DIST_W-1:0] min_dl;
    logic [DIST_W-1:0] min_all;

    // On a byte match take the diagonal value, else the smallest neighbor plus one
    always_comb begin
        min_dl  = (i_cell.diag < i_cell.left) ? i_cell.diag : i_cell.left;
        min_all = (min_dl < i_cell.up) ? min_dl : i_cell.up;
        if (i_cell.bytes_eq) begin
            o_value = i_cell.diag;
        end else begin
            o_value = min_all + DIST_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/levenshtein_distance.sv -----
// ----------------------------------------------------------------------------
// levenshtein_distance
// Unit-cost edit distance between a stored reference string and a streamed
// string, one row of the dynamic programming table per streamed byte.
// ----------------------------------------------------------------------------
// Words arrive on the slave stream with the mode in tuser: load appends a
// reference byte (dropped with the overflow flag once MAX_REF_LEN bytes are
// held, ignored once streaming has begun), stream runs one byte of the other
// string against the reference, finish emits distance, longer length and
// overflow on the master stream and clears the job. A stream walks the
// row with one shared cell unit, each entry needing a registered read of
// the reference and row memories followed by an update and write-back.
// A finish places the result in the output register, waiting there while
// the previous result has not been taken. Mode three is ignored. Memories
// need no clear: the first streamed byte of a job uses index values in
// place of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module levenshtein_distance
    import lev_pkg::*;
#(
    parameter int unsigned MAX_REF_LEN = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] mode
    // master stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [15:0] edit_distance,
                                          // [31:16] longer_length,
                                          // [32] overflow, [39:33] zero
);

    localparam int unsigned CW = $clog2(MAX_REF_LEN + 1);
    localparam int unsigned AW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
    localparam logic [CW-1:0] REF_FULL = CW'(MAX_REF_LEN);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CALC = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]     r_ref_cnt, n_ref_cnt;
    logic [DIST_W-1:0] r_str_cnt, n_str_cnt;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_j, n_j;
    logic [7:0]        r_c, n_c;
    logic              r_first, n_first;
    logic [DIST_W-1:0] r_diag, n_diag;
    logic [DIST_W-1:0] r_left, n_left;
    logic [DIST_W-1:0] r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_out_dist, n_out_dist;
    logic [DIST_W-1:0] r_out_len, n_out_len;
    logic              r_out_ovf, n_out_ovf;

    // Memories: reference bytes and row entries 1..N (entry 0 is implicit)
    logic [7:0]        r_ref_mem [MAX_REF_LEN];
    logic [DIST_W-1:0] r_row_mem [MAX_REF_LEN];
    logic [7:0]        r_ref_rd;
    logic [DIST_W-1:0] r_row_rd;

    logic              s_accept;
    logic              ref_we;
    logic              row_we;
    logic [DIST_W-1:0] n_ext;
    logic [DIST_W-1:0] j_ext;
    t_cell_in          cell_in;
    logic [DIST_W-1:0] cell_value;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign n_ext           = DIST_W'(r_ref_cnt);
    assign j_ext           = DIST_W'(r_j);

    // Assemble the operands of the current cell
    always_comb begin
        cell_in.bytes_eq = (r_c == r_ref_rd);
        cell_in.diag     = r_diag;
        cell_in.left     = r_left;
        cell_in.up       = r_first ? (j_ext + DIST_W'(1)) : r_row_rd;
    end

    lev_cell u_cell (
        .i_cell  (cell_in),
        .o_value (cell_value)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ref_cnt   = r_ref_cnt;
        n_str_cnt   = r_str_cnt;
        n_ovf       = r_ovf;
        n_j         = r_j;
        n_c         = r_c;
        n_first     = r_first;
        n_diag      = r_diag;
        n_left      = r_left;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        ref_we      = 1'b0;
        row_we      = 1'b0;

        // drop the result once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        MODE_LOAD: begin
                            if (r_str_cnt == '0) begin
                                if (r_ref_cnt == REF_FULL) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    ref_we    = 1'b1;
                                    n_ref_cnt = r_ref_cnt + CW'(1);
                                end
                            end
                        end
                        MODE_STREAM: begin
                            if (r_str_cnt == STREAM_LIMIT) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_c       = i_s_axis_tdata;
                                n_first   = (r_str_cnt == '0);
                                n_diag    = r_str_cnt;
                                n_left    = r_str_cnt + DIST_W'(1);
                                n_last    = r_str_cnt + DIST_W'(1);
                                n_j       = '0;
                                n_str_cnt = r_str_cnt + DIST_W'(1);
                                if (r_ref_cnt != '0) begin
                                    n_state = S_RD;
                                end
                            end
                        end
                        MODE_FINISH: begin
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                // write back, shift the window one entry right
                row_we  = 1'b1;
                n_diag  = cell_in.up;
                n_left  = cell_value;
                n_last  = cell_value;
                n_j     = r_j + CW'(1);
                if ((r_j + CW'(1)) == r_ref_cnt) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = (r_str_cnt == '0) ? n_ext : r_last;
                    n_out_len   = (n_ext > r_str_cnt) ? n_ext : r_str_cnt;
                    n_out_ovf   = r_ovf;
                    n_ref_cnt   = '0;
                    n_str_cnt   = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_cnt   <= '0;
            r_str_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_cnt   <= n_ref_cnt;
            r_str_cnt   <= n_str_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_c        <= n_c;
        r_first    <= n_first;
        r_diag     <= n_diag;
        r_left     <= n_left;
        r_last     <= n_last;
        r_out_dist <= n_out_dist;
        r_out_len  <= n_out_len;
        r_out_ovf  <= n_out_ovf;
    end

    // Reference memory
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[r_ref_cnt[AW-1:0]] <= i_s_axis_tdata;
        end
        if (r_state == S_RD) begin
            r_ref_rd <= r_ref_mem[r_j[AW-1:0]];
        end
    end

    // Row memory
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[r_j[AW-1:0]] <= cell_value;
        end
        if (r_state == S_RD) begin
            r_row_rd <= r_row_mem[r_j[AW-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_ovf, r_out_len, r_out_dist};

endmodule

`default_nettype wire
